### hdl/lsb_stego_payload_extractor_defines.svh
// assertion macros for the lsb stego payload extractor
// used by the top level only, expects clk and arst_n in scope
`ifndef LSB_STEGO_PAYLOAD_EXTRACTOR_DEFINES_SVH
`define LSB_STEGO_PAYLOAD_EXTRACTOR_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define LSBX_CHECK(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("lsbx check failed");

// implication checked in the same cycle
`define LSBX_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsbx implication failed");

`endif

### hdl/lsbx_pkg.sv
// shared types, codes and constants of the lsb stego payload extractor
// no dependencies
`timescale 1ns / 1ps

package lsbx_pkg;

	// fixed format constants
	localparam int BMP_HEADER_BYTES    = 54;
	localparam int LENGTH_FIELD_BITS   = 32;
	localparam int MAX_EXT_LEN_DEFAULT = 32;
	localparam int FIXED_OVERHEAD      = 10;
	localparam int BYTE_BITS           = 8;
	localparam int MAGIC_BITS          = 16;

	localparam logic [7:0]  CHAR_B      = 8'h42;
	localparam logic [7:0]  CHAR_M      = 8'h4D;
	localparam logic [15:0] MAGIC_RESET = 16'd10787;

	// widths
	localparam int HDR_W   = 6;
	localparam int BIT_W   = 5;
	localparam int SHIFT_W = 32;
	localparam int LEN_W   = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 1;

	// result queue depth
	localparam int RF_DEPTH = 4;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FLEN  = 1'b1;

	// result kinds
	localparam logic [1:0] KIND_EXT    = 2'd0;
	localparam logic [1:0] KIND_PAY    = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MAGIC    = 2'd1;
	localparam logic [1:0] ST_TRUNC    = 2'd2;
	localparam logic [1:0] ST_EXT_LONG = 2'd3;

	typedef enum logic [3:0] {
		PH_DETECT,
		PH_SECOND,
		PH_HEADER,
		PH_MAGIC,
		PH_EXTLEN,
		PH_EXT,
		PH_PAYLEN,
		PH_PAYLSB,
		PH_PAYRAW,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       value;
		logic [1:0]       status;
		logic [LEN_W-1:0] length;
		logic             last;
	} res_t;

	// up to two results written into the queue in one cycle, r0 first
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

### hdl/lsb_stego_payload_extractor.sv
// lsb stego payload extractor: one file byte per word, results lsb-decoded
// results come from the input word register through the result queue
// throughput: one byte per cycle but for stalls; two results take two slots
// the four-entry result queue stalls input only when it is nearly full
// reset: arst_n clears parse state and queue, registers go to defaults
`timescale 1ns / 1ps
`include "lsb_stego_payload_extractor_defines.svh"

module lsb_stego_payload_extractor #(
	parameter int MAX_EXT_LEN = lsbx_pkg::MAX_EXT_LEN_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [lsbx_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [lsbx_pkg::CFG_W-1:0]        wr_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        in_byte,
	input  logic                              in_last,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        out_kind,
	output logic [7:0]                        out_value,
	output logic [1:0]                        out_status,
	output logic [lsbx_pkg::LEN_W-1:0]        out_length,
	output logic                              out_last
);
	import lsbx_pkg::*;

	logic [15:0]      magic_q;
	logic [LEN_W-1:0] flen_q;
	push_t            push;
	logic             fifo_room;
	res_t             head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= MAGIC_RESET;
			flen_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_MAGIC: magic_q <= wr_data[15:0];
				REG_FLEN:  flen_q  <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	lsbx_core #(
		.MAX_EXT_LEN(MAX_EXT_LEN)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.magic_word (magic_q),
		.file_length(flen_q),
		.room       (fifo_room),
		.push       (push)
	);

	lsbx_rfifo u_rfifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (fifo_room),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head     (head)
	);

	assign out_kind   = head.kind;
	assign out_value  = head.value;
	assign out_status = head.status;
	assign out_length = head.length;
	assign out_last   = head.last;

	// checks
	`LSBX_CHECK(a_push_needs_room, !((push.cnt != 2'd0) && !fifo_room))
	`LSBX_IMPLY(a_second_is_status, push.cnt == 2'd2, push.r1.kind == KIND_STATUS && push.r1.last)
	`LSBX_IMPLY(a_last_is_status, out_valid && out_last, out_kind == KIND_STATUS)
	`LSBX_IMPLY(a_byte_fields_zero, out_valid && out_kind != KIND_STATUS, out_status == ST_OK && out_length == '0 && !out_last)

endmodule

### hdl/lsbx_core.sv
// decode core: input word register, parse state and result generation
// depends on lsbx_pkg
`timescale 1ns / 1ps

module lsbx_core #(
	parameter int MAX_EXT_LEN = lsbx_pkg::MAX_EXT_LEN_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             in_byte,
	input  logic                   in_last,
	input  logic [15:0]            magic_word,
	input  logic [lsbx_pkg::LEN_W-1:0] file_length,
	input  logic                   room,
	output lsbx_pkg::push_t        push
);
	import lsbx_pkg::*;

	localparam int EXT_W = $clog2(MAX_EXT_LEN + 1);

	// input word register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       fire;

	// parse state
	phase_t             phase_q, phase_d;
	logic [7:0]         first_q, first_d;
	logic               bitmap_q, bitmap_d;
	logic [HDR_W-1:0]   hleft_q, hleft_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [SHIFT_W-1:0] shift_q, shift_d;
	logic [EXT_W-1:0]   ext_q, ext_d;
	logic [LEN_W-1:0]   paylen_q, paylen_d;
	logic [LEN_W-1:0]   lsbcnt_q, lsbcnt_d;
	logic [LEN_W-1:0]   items_q, items_d;

	// capacity, kept up to date from the state
	logic [LEN_W-1:0] lsbcap_q, cap_q;
	logic [LEN_W-1:0] hdr_len, over_len;

	// shared decode
	logic               b0, f0;
	logic [SHIFT_W-1:0] acc;
	logic [BIT_W:0]     bit_next, need;
	logic               field_done;
	logic               ext_too_long;
	logic               is_bm;

	// results
	logic             byte_emit, fin, trunc, stat_emit;
	logic [1:0]       byte_kind, fin_status;
	logic [7:0]       byte_val;
	logic [LEN_W-1:0] stat_len;
	res_t             byte_res, stat_res;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	// bit gathering, lsb first
	assign b0  = byte_s1[0];
	assign f0  = first_q[0];
	assign acc = shift_q | (SHIFT_W'(b0) << bit_q);
	assign bit_next = {1'b0, bit_q} + (BIT_W+1)'(1);
	assign ext_too_long = acc > SHIFT_W'(MAX_EXT_LEN);
	assign is_bm = (first_q == CHAR_B) && (byte_s1 == CHAR_M);

	always_comb begin
		case (phase_q)
			PH_MAGIC: need = (BIT_W+1)'(MAGIC_BITS);
			PH_EXTLEN, PH_PAYLEN: need = (BIT_W+1)'(LENGTH_FIELD_BITS);
			default: need = (BIT_W+1)'(BYTE_BITS);
		endcase
	end

	assign field_done = bit_next == need;

	// capacity in two register steps
	assign hdr_len  = bitmap_q ? LEN_W'(BMP_HEADER_BYTES) : '0;
	assign over_len = LEN_W'(FIXED_OVERHEAD) + LEN_W'(ext_q);

	always_ff @(posedge clk) begin
		lsbcap_q <= (file_length > hdr_len) ? file_length - hdr_len : '0;
		cap_q    <= (lsbcap_q > over_len) ? lsbcap_q - over_len : '0;
	end

	// next state
	always_comb begin
		phase_d  = phase_q;
		first_d  = first_q;
		bitmap_d = bitmap_q;
		hleft_d  = hleft_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		ext_d    = ext_q;
		paylen_d = paylen_q;
		lsbcnt_d = lsbcnt_q;
		items_d  = items_q;
		if (fire) begin
			case (phase_q)
				PH_DETECT: begin
					first_d = byte_s1;
					phase_d = PH_SECOND;
				end
				PH_SECOND: begin
					bitmap_d = is_bm;
					if (!is_bm) begin
						phase_d = PH_MAGIC;
						shift_d = {{(SHIFT_W-2){1'b0}}, b0, f0};
						bit_d   = BIT_W'(2);
					end else if (BMP_HEADER_BYTES > 2) begin
						hleft_d = HDR_W'(BMP_HEADER_BYTES - 2);
						phase_d = PH_HEADER;
					end else begin
						phase_d = PH_MAGIC;
						// tiny header: the marker bytes past it carry data
						if (BMP_HEADER_BYTES == 1) begin
							shift_d = SHIFT_W'(b0);
							bit_d   = BIT_W'(1);
						end else if (BMP_HEADER_BYTES == 0) begin
							shift_d = {{(SHIFT_W-2){1'b0}}, b0, f0};
							bit_d   = BIT_W'(2);
						end
					end
				end
				PH_HEADER: begin
					if (hleft_q != '0)
						hleft_d = hleft_q - HDR_W'(1);
					if (hleft_q <= HDR_W'(1))
						phase_d = PH_MAGIC;
				end
				PH_MAGIC, PH_EXTLEN, PH_EXT, PH_PAYLEN, PH_PAYLSB: begin
					shift_d = acc;
					bit_d   = bit_next[BIT_W-1:0];
					if (field_done) begin
						shift_d = '0;
						bit_d   = '0;
						case (phase_q)
							PH_MAGIC: begin
								phase_d = (acc[15:0] != magic_word) ? PH_DONE : PH_EXTLEN;
							end
							PH_EXTLEN: begin
								ext_d = EXT_W'(acc);
								if (ext_too_long) begin
									phase_d = PH_DONE;
								end else begin
									items_d = acc;
									phase_d = (acc == '0) ? PH_PAYLEN : PH_EXT;
								end
							end
							PH_EXT: begin
								items_d = items_q - LEN_W'(1);
								if (items_q == LEN_W'(1))
									phase_d = PH_PAYLEN;
							end
							PH_PAYLEN: begin
								paylen_d = acc;
								lsbcnt_d = (acc > cap_q) ? cap_q : acc;
								items_d  = acc;
								if (acc == '0)
									phase_d = PH_DONE;
								else if (cap_q != '0)
									phase_d = PH_PAYLSB;
								else
									phase_d = PH_PAYRAW;
							end
							default: begin
								lsbcnt_d = lsbcnt_q - LEN_W'(1);
								items_d  = items_q - LEN_W'(1);
								if (items_q == LEN_W'(1))
									phase_d = PH_DONE;
								else if (lsbcnt_q == LEN_W'(1))
									phase_d = PH_PAYRAW;
							end
						endcase
					end
				end
				PH_PAYRAW: begin
					items_d = items_q - LEN_W'(1);
					if (items_q == LEN_W'(1))
						phase_d = PH_DONE;
				end
				default: ;
			endcase
			// end of file puts everything back to the start
			if (last_s1) begin
				phase_d  = PH_DETECT;
				first_d  = '0;
				bitmap_d = 1'b0;
				hleft_d  = '0;
				bit_d    = '0;
				shift_d  = '0;
				ext_d    = '0;
				paylen_d = '0;
				lsbcnt_d = '0;
				items_d  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DETECT;
			first_q  <= '0;
			bitmap_q <= 1'b0;
			hleft_q  <= '0;
			bit_q    <= '0;
			shift_q  <= '0;
			ext_q    <= '0;
			paylen_q <= '0;
			lsbcnt_q <= '0;
			items_q  <= '0;
		end else begin
			phase_q  <= phase_d;
			first_q  <= first_d;
			bitmap_q <= bitmap_d;
			hleft_q  <= hleft_d;
			bit_q    <= bit_d;
			shift_q  <= shift_d;
			ext_q    <= ext_d;
			paylen_q <= paylen_d;
			lsbcnt_q <= lsbcnt_d;
			items_q  <= items_d;
		end
	end

	// results of the word in the input register
	always_comb begin
		byte_emit  = 1'b0;
		byte_kind  = KIND_PAY;
		byte_val   = acc[7:0];
		fin        = 1'b0;
		fin_status = ST_OK;
		stat_len   = '0;
		if (fire) begin
			case (phase_q)
				PH_MAGIC: begin
					if (field_done && acc[15:0] != magic_word) begin
						fin        = 1'b1;
						fin_status = ST_MAGIC;
					end
				end
				PH_EXTLEN: begin
					if (field_done && ext_too_long) begin
						fin        = 1'b1;
						fin_status = ST_EXT_LONG;
					end
				end
				PH_EXT: begin
					if (field_done) begin
						byte_emit = 1'b1;
						byte_kind = KIND_EXT;
					end
				end
				PH_PAYLEN: begin
					if (field_done && acc == '0)
						fin = 1'b1;
				end
				PH_PAYLSB: begin
					if (field_done) begin
						byte_emit = 1'b1;
						if (items_q == LEN_W'(1)) begin
							fin      = 1'b1;
							stat_len = paylen_q;
						end
					end
				end
				PH_PAYRAW: begin
					byte_emit = 1'b1;
					byte_val  = byte_s1;
					if (items_q == LEN_W'(1)) begin
						fin      = 1'b1;
						stat_len = paylen_q;
					end
				end
				default: ;
			endcase
		end

		// file ended before the decode finished
		trunc = fire && last_s1 && !fin && (phase_q != PH_DONE);
		if (trunc)
			stat_len = (phase_q == PH_PAYLEN && field_done) ? acc : paylen_q;

		stat_emit = fin || trunc;

		byte_res.kind   = byte_kind;
		byte_res.value  = byte_val;
		byte_res.status = ST_OK;
		byte_res.length = '0;
		byte_res.last   = 1'b0;

		stat_res.kind   = KIND_STATUS;
		stat_res.value  = '0;
		stat_res.status = trunc ? ST_TRUNC : fin_status;
		stat_res.length = stat_len;
		stat_res.last   = 1'b1;

		push.cnt = {1'b0, byte_emit} + {1'b0, stat_emit};
		push.r0  = byte_emit ? byte_res : stat_res;
		push.r1  = stat_res;
	end

endmodule

### hdl/lsbx_rfifo.sv
// result queue: takes up to two results a cycle, hands out one
// depends on lsbx_pkg
`timescale 1ns / 1ps

module lsbx_rfifo (
	input  logic             clk,
	input  logic             arst_n,
	input  lsbx_pkg::push_t  push,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output lsbx_pkg::res_t   head
);
	import lsbx_pkg::*;

	localparam int PTR_W = $clog2(RF_DEPTH);
	localparam int CNT_W = $clog2(RF_DEPTH + 1);

	res_t             mem [RF_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q, wp_inc;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign out_valid = count_q != '0;
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= CNT_W'(RF_DEPTH - 2);
	assign wp_inc    = wp_q + PTR_W'(1);
	assign head      = mem[rp_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			mem[wp_q] <= push.r0;
		if (push.cnt == 2'd2)
			mem[wp_inc] <= push.r1;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + PTR_W'(push.cnt);
			if (pop)
				rp_q <= rp_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push.cnt) - CNT_W'(pop);
		end
	end

endmodule

### dv/tb_top.sv
// testbench for the lsb stego payload extractor: builds stego files, streams them
// byte by byte and checks every decoded word against an in-bench decoder
// depends on lsbx_pkg and the lsb_stego_payload_extractor top level
`timescale 1ns / 1ps

module tb_top;

	import lsbx_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int PAY_GEN_MAX   = 12;
	localparam int TOTAL_WORDS   = 1350;
	localparam int DRAIN_LIMIT   = 5000;

	// clock, reset and block ports
	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 wr_en      = 1'b0;
	logic [CFG_IDX_W-1:0] wr_index   = REG_MAGIC;
	logic [CFG_W-1:0]     wr_data    = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [7:0]           in_byte    = 8'd0;
	logic                 in_last    = 1'b0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [1:0]           out_kind;
	logic [7:0]           out_value;
	logic [1:0]           out_status;
	logic [LEN_W-1:0]     out_length;
	logic                 out_last;

	lsb_stego_payload_extractor dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_kind   (out_kind),
		.out_value  (out_value),
		.out_status (out_status),
		.out_length (out_length),
		.out_last   (out_last)
	);

	always #1 clk = ~clk;

	// bench bookkeeping
	res_t        decoded_q[$];
	res_t        want_r;
	logic [7:0]  file_bytes[$];
	bit          steady = 1'b0;
	int unsigned errors = 0;
	int unsigned checked = 0;
	int unsigned files_sent = 0;
	int unsigned words_sent = 0;
	int unsigned data_words = 0;
	int unsigned status_seen[4];

	// register copies
	logic [15:0] magic_cfg = MAGIC_RESET;
	logic [31:0] flen_cfg  = '0;

	// decoder state
	phase_t      ph;
	logic [7:0]  first_b;
	logic        is_bmp;
	int unsigned hdr_left;
	int unsigned bit_cnt;
	logic [31:0] shift_acc;
	logic [31:0] ext_len_d;
	logic [31:0] pay_len_d;
	logic [31:0] lsb_left;
	logic [31:0] items_left_d;

	function automatic void decode_clear();
		ph           = PH_DETECT;
		first_b      = '0;
		is_bmp       = 1'b0;
		hdr_left     = 0;
		bit_cnt      = 0;
		shift_acc    = '0;
		ext_len_d    = '0;
		pay_len_d    = '0;
		lsb_left     = '0;
		items_left_d = '0;
	endfunction

	function automatic void push_result(logic [1:0] k, logic [7:0] v, logic [1:0] s,
			logic [31:0] len, logic l);
		res_t r;
		r.kind   = k;
		r.value  = v;
		r.status = s;
		r.length = len;
		r.last   = l;
		decoded_q.push_back(r);
	endfunction

	function automatic void end_decode(logic [1:0] s, logic [31:0] len);
		ph = PH_DONE;
		push_result(KIND_STATUS, 8'd0, s, len, 1'b1);
	endfunction

	// one data byte: raw payload byte, or one lsb into the current field
	function automatic void take_byte(logic [7:0] b);
		int unsigned       need;
		logic [31:0]       v;
		longint unsigned   hdr;
		longint unsigned   over;
		longint unsigned   room;
		longint unsigned   cap;
		if (ph == PH_PAYRAW) begin
			push_result(KIND_PAY, b, ST_OK, '0, 1'b0);
			items_left_d--;
			if (items_left_d == 0)
				end_decode(ST_OK, pay_len_d);
			return;
		end
		if (ph < PH_MAGIC || ph > PH_PAYLSB)
			return;
		shift_acc = shift_acc | (32'(b[0]) << bit_cnt);
		bit_cnt++;
		if (ph == PH_MAGIC)
			need = MAGIC_BITS;
		else if (ph == PH_EXTLEN || ph == PH_PAYLEN)
			need = LENGTH_FIELD_BITS;
		else
			need = BYTE_BITS;
		if (bit_cnt < need)
			return;
		v = shift_acc;
		shift_acc = '0;
		bit_cnt = 0;
		case (ph)
			PH_MAGIC: begin
				if (v != {16'd0, magic_cfg})
					end_decode(ST_MAGIC, '0);
				else
					ph = PH_EXTLEN;
			end
			PH_EXTLEN: begin
				ext_len_d = v;
				if (v > MAX_EXT_LEN_DEFAULT) begin
					end_decode(ST_EXT_LONG, '0);
				end else begin
					items_left_d = v;
					ph = (v == 0) ? PH_PAYLEN : PH_EXT;
				end
			end
			PH_EXT: begin
				push_result(KIND_EXT, v[7:0], ST_OK, '0, 1'b0);
				items_left_d--;
				if (items_left_d == 0)
					ph = PH_PAYLEN;
			end
			PH_PAYLEN: begin
				// lsb capacity left after header, fixed fields and extension
				hdr  = is_bmp ? BMP_HEADER_BYTES : 0;
				over = FIXED_OVERHEAD + 64'(ext_len_d);
				room = (64'(flen_cfg) > hdr) ? 64'(flen_cfg) - hdr : 0;
				cap  = (room > over) ? room - over : 0;
				pay_len_d = v;
				if (64'(v) > cap)
					lsb_left = cap[31:0];
				else
					lsb_left = v;
				items_left_d = v;
				if (items_left_d == 0)
					end_decode(ST_OK, pay_len_d);
				else
					ph = (lsb_left > 0) ? PH_PAYLSB : PH_PAYRAW;
			end
			default: begin
				push_result(KIND_PAY, v[7:0], ST_OK, '0, 1'b0);
				lsb_left--;
				items_left_d--;
				if (items_left_d == 0)
					end_decode(ST_OK, pay_len_d);
				else if (lsb_left == 0)
					ph = PH_PAYRAW;
			end
		endcase
	endfunction

	// one accepted file byte
	function automatic void lsb_decode_step(logic [7:0] b, logic last);
		case (ph)
			PH_DETECT: begin
				first_b = b;
				ph = PH_SECOND;
			end
			PH_SECOND: begin
				if (first_b == CHAR_B && b == CHAR_M) begin
					is_bmp = 1'b1;
					hdr_left = BMP_HEADER_BYTES - 2;
					ph = PH_HEADER;
				end else begin
					is_bmp = 1'b0;
					ph = PH_MAGIC;
					take_byte(first_b);
					take_byte(b);
				end
			end
			PH_HEADER: begin
				if (hdr_left > 0)
					hdr_left--;
				if (hdr_left == 0)
					ph = PH_MAGIC;
			end
			default: take_byte(b);
		endcase
		if (last) begin
			if (ph != PH_DONE)
				push_result(KIND_STATUS, 8'd0, ST_TRUNC, pay_len_d, 1'b1);
			decode_clear();
		end
	endfunction

	task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task compare_field(input string what, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// predict on accepted input words, check accepted result words
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			lsb_decode_step(in_byte, in_last);
		if (arst_n && out_valid && out_ready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("unexpected word, kind", 32'(out_kind), '0);
			end else begin
				want_r = decoded_q.pop_front();
				compare_field("kind", 32'(out_kind), 32'(want_r.kind));
				compare_field("value", 32'(out_value), 32'(want_r.value));
				compare_field("status", 32'(out_status), 32'(want_r.status));
				compare_field("length", out_length, want_r.length);
				compare_field("last", 32'(out_last), 32'(want_r.last));
				checked++;
				if (want_r.kind == KIND_STATUS)
					status_seen[want_r.status]++;
			end
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 26);
	end

	function automatic bit take_gap();
		return !steady && ($urandom_range(0, 99) < 26);
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	// send one word and wait for it to be taken
	task send_word(input logic [7:0] b, input logic l);
		while (take_gap()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	task send_file();
		for (int i = 0; i < file_bytes.size(); i++)
			send_word(file_bytes[i], i == file_bytes.size() - 1);
		in_valid <= 1'b0;
		files_sent++;
	endtask

	task wait_idle();
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both registers once the block is quiet
	task set_regs(input logic [31:0] magic_data, input logic [31:0] flen);
		wait_idle();
		wr_en    <= 1'b1;
		wr_index <= REG_MAGIC;
		wr_data  <= magic_data;
		@(posedge clk);
		magic_cfg = magic_data[15:0];
		wr_index <= REG_FLEN;
		wr_data  <= flen;
		@(posedge clk);
		flen_cfg = flen;
		wr_en <= 1'b0;
	endtask

	// lsb-encode a value into random carrier bytes
	function automatic void put_lsbs(logic [31:0] v, int n);
		logic [7:0] r;
		for (int i = 0; i < n; i++) begin
			r = rand_byte();
			r[0] = v[i];
			file_bytes.push_back(r);
			data_words++;
		end
	endfunction

	// assemble one stego file into file_bytes
	function automatic void build_file(bit bmp, logic [15:0] mg, logic [31:0] ext_n,
			logic [31:0] pay_n, int unsigned gen_n, int unsigned lsb_n, int unsigned trail);
		file_bytes.delete();
		if (bmp) begin
			file_bytes.push_back(CHAR_B);
			file_bytes.push_back(CHAR_M);
			for (int i = 2; i < BMP_HEADER_BYTES; i++)
				file_bytes.push_back(rand_byte());
		end
		put_lsbs({16'd0, mg}, MAGIC_BITS);
		put_lsbs(ext_n, LENGTH_FIELD_BITS);
		if (ext_n <= MAX_EXT_LEN_DEFAULT)
			for (int i = 0; i < ext_n; i++)
				put_lsbs(32'(rand_byte()), BYTE_BITS);
		put_lsbs(pay_n, LENGTH_FIELD_BITS);
		for (int i = 0; i < gen_n; i++) begin
			if (i < lsb_n) begin
				put_lsbs(32'(rand_byte()), BYTE_BITS);
			end else begin
				file_bytes.push_back(rand_byte());
				data_words++;
			end
		end
		for (int i = 0; i < trail; i++)
			file_bytes.push_back(rand_byte());
	endfunction

	// one-byte and two-byte files end before any field is decoded
	task test_short_files();
		file_bytes = '{8'h00};
		send_file();
		file_bytes = '{8'hFF};
		send_file();
		file_bytes = '{CHAR_B, CHAR_M};
		send_file();
		file_bytes = '{CHAR_M, CHAR_B};
		send_file();
	endtask

	// reset magic, file carries a different one, then trailing bytes
	task test_magic_mismatch();
		build_file(1'b0, ~MAGIC_RESET, '0, '0, 0, 0, 3);
		send_file();
	endtask

	// bitmap with empty extension and payload, trailing bytes after status
	task test_zero_payload();
		build_file(1'b1, MAGIC_RESET, '0, '0, 0, 0, 4);
		send_file();
	endtask

	task test_ext_too_long();
		set_regs(32'hFFFF_FFFF, '0);
		build_file(1'b0, 16'hFFFF, MAX_EXT_LEN_DEFAULT + 1, '0, 0, 0, 2);
		send_file();
		build_file(1'b1, 16'hFFFF, 32'hFFFF_FFFF, '0, 0, 0, 0);
		send_file();
	endtask

	// capacity of two bytes, the other three payload bytes come raw
	task test_lsb_then_raw();
		set_regs('0, BMP_HEADER_BYTES + FIXED_OVERHEAD + 2 + 2);
		build_file(1'b1, 16'h0000, 32'd2, 32'd5, 5, 2, 0);
		send_file();
	endtask

	// longest extension, all-ones payload length, file ends early
	// sent as one long stretch with no stalls on either side
	task test_length_extremes();
		set_regs({16'h5A5A, 16'h1234}, 32'hFFFF_FFFF);
		build_file(1'b0, 16'h1234, MAX_EXT_LEN_DEFAULT, 32'hFFFF_FFFF,
			PAY_GEN_MAX, PAY_GEN_MAX, 0);
		steady = 1'b1;
		send_file();
		steady = 1'b0;
	endtask

	// short random byte runs, often starting like a bitmap
	task noise_file();
		int unsigned len;
		len = $urandom_range(1, 20);
		file_bytes.delete();
		for (int i = 0; i < len; i++)
			file_bytes.push_back(rand_byte());
		if ($urandom_range(0, 99) < 30)
			file_bytes[0] = CHAR_B;
		if (len > 1 && $urandom_range(0, 99) < 40)
			file_bytes[1] = CHAR_M;
		data_words += len;
		send_file();
	endtask

	// mostly well-formed file with random content and random settings
	task random_file();
		bit          bmp;
		logic [15:0] reg_magic;
		logic [15:0] file_magic;
		logic [31:0] ext_n;
		logic [31:0] pay_n;
		logic [31:0] flen;
		int unsigned gen_n;
		int unsigned lsb_n;
		int unsigned trail;
		int unsigned hdr;
		int unsigned pick;
		int unsigned cut;
		bmp = $urandom_range(0, 1);
		hdr = bmp ? BMP_HEADER_BYTES : 0;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			reg_magic = 16'h0000;
		else if (pick < 20)
			reg_magic = 16'hFFFF;
		else
			reg_magic = 16'($urandom);
		file_magic = reg_magic;
		if ($urandom_range(0, 99) < 12)
			file_magic = reg_magic ^ 16'($urandom_range(1, 65535));
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			ext_n = $urandom_range(0, 1) ? 32'($urandom_range(33, 40)) : 32'($urandom);
			if (ext_n <= MAX_EXT_LEN_DEFAULT)
				ext_n += MAX_EXT_LEN_DEFAULT + 1;
		end else if (pick < 15) begin
			ext_n = MAX_EXT_LEN_DEFAULT;
		end else begin
			ext_n = $urandom_range(0, 4);
		end
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			pay_n = $urandom;
			if (pay_n <= PAY_GEN_MAX)
				pay_n += PAY_GEN_MAX + 1;
		end else if (pick < 18) begin
			pay_n = '0;
		end else begin
			pay_n = $urandom_range(1, 10);
		end
		gen_n = (pay_n > PAY_GEN_MAX) ? PAY_GEN_MAX : pay_n;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			flen  = '0;
			lsb_n = 0;
		end else if (pick < 20) begin
			flen  = '1;
			lsb_n = gen_n;
		end else begin
			lsb_n = $urandom_range(0, gen_n);
			flen  = hdr + FIXED_OVERHEAD + ext_n + lsb_n;
		end
		trail = ($urandom_range(0, 99) < 20) ? $urandom_range(1, 6) : 0;
		set_regs({16'($urandom), reg_magic}, flen);
		build_file(bmp, file_magic, ext_n, pay_n, gen_n, lsb_n, trail);
		// cut some files short anywhere, header included
		if ($urandom_range(0, 99) < 12) begin
			cut = $urandom_range(1, file_bytes.size());
			while (file_bytes.size() > cut)
				void'(file_bytes.pop_back());
		end
		send_file();
	endtask

	// random files until the overall word budget is used up
	task test_random();
		while (words_sent < TOTAL_WORDS) begin
			if ($urandom_range(0, 99) < 10)
				noise_file();
			else
				random_file();
		end
	endtask

	// reset, directed tests, random tests, drain and verdict
	initial begin
		int unsigned guard;
		decode_clear();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_files();
		test_magic_mismatch();
		test_zero_payload();
		test_ext_too_long();
		test_lsb_then_raw();
		test_length_extremes();
		test_random();
		guard = 0;
		while (decoded_q.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (decoded_q.size() != 0)
			report_mismatch("words never seen, count", decoded_q.size(), '0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d files, %0d bytes sent (%0d data bytes), %0d result words checked",
			files_sent, words_sent, data_words, checked);
		$display("status words: ok %0d, bad magic %0d, truncated %0d, ext too long %0d",
			status_seen[ST_OK], status_seen[ST_MAGIC], status_seen[ST_TRUNC],
			status_seen[ST_EXT_LONG]);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// run limit
	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
